>>> hw/rtl/gtrm_pkg.sv
package gtrm_pkg;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam int CODE_BITS = 6;

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int W_W    = $clog2(GRID_COLS + 1);
  localparam int H_W    = $clog2(GRID_ROWS + 1);

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);

  localparam logic [1:0] STATUS_LOADED = 2'd0;
  localparam logic [1:0] STATUS_RECT   = 2'd1;
  localparam logic [1:0] STATUS_NONE   = 2'd2;

  localparam logic MODE_LOAD = 1'b0;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 solid;
  } cell_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
  } grid_wr_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ADDR_W'(row) * ADDR_W'(GRID_COLS));
    return ADDR_W'(base + ADDR_W'(col));
  endfunction

endpackage

>>> hw/rtl/gtrm_grid_ram.sv
module gtrm_grid_ram (
  input  logic                      clk,
  input  gtrm_pkg::grid_wr_t        wr,
  input  logic [gtrm_pkg::ADDR_W-1:0] rd_addr,
  output gtrm_pkg::cell_t           rd_data
);
  import gtrm_pkg::*;

  cell_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/greedy_tile_rect_mesher_top.sv
// Greedy rectangle mesher over a 16 x 16 grid of tile codes. A load item within the grid writes
// one cell (code, solid flag), clears its meshed mark and restarts the scan. A fetch item walks
// the grid in raster order one cell per cycle past meshed cells, then grows the rectangle right
// and then down, reading each compared cell in a read state before comparing it in a compare
// state because the single read port of the grid memory returns registered data, and finally
// marks the rectangle one cell per cycle. Once the scan has finished, a fetch returns status 2.
// One item is in work at a time; the result sits in an output register, and simple_floor is
// written through the cfg channel; the user must write it only while the block is idle, as
// the block does not enforce this.
module greedy_tile_rect_mesher_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [3:0] cell_row,
  input  logic [3:0] cell_col,
  input  logic [5:0] cell_code,
  input  logic       cell_solid,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [3:0] rect_row,
  output logic [3:0] rect_col,
  output logic [4:0] rect_width,
  output logic [4:0] rect_height,
  output logic [5:0] rect_code,
  output logic       rect_solid,
  output logic       needs_texture,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import gtrm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_REF  = 4'd2;
  localparam logic [3:0] S_WRD  = 4'd3;
  localparam logic [3:0] S_WCMP = 4'd4;
  localparam logic [3:0] S_HRD  = 4'd5;
  localparam logic [3:0] S_HCMP = 4'd6;
  localparam logic [3:0] S_MARK = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]       state;
  logic             simple_floor;
  logic [CELLS-1:0] meshed;
  logic [ROW_W-1:0] scan_row;
  logic [COL_W-1:0] scan_col;
  logic             scan_end;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [W_W-1:0]   w;
  logic [H_W-1:0]   h;
  logic [W_W-1:0]   ccount;
  logic [H_W-1:0]   rcount;
  cell_t            ref_cell;
  logic [1:0]       res_status;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;

  grid_wr_t          grid_wr;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr;
  cell_t             rd_data;
  logic              in_xfer;
  logic              out_free;
  logic              load_in_range;
  logic              probe_eq;

  assign scan_addr = cell_addr(scan_row, scan_col);
  assign cur_addr  = cell_addr(cur_row, cur_col);
  assign rd_addr   = (state == S_SCAN) ? scan_addr : cur_addr;

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  assign load_in_range = ({3'b0, cell_row} < 7'(GRID_ROWS)) &&
                         ({3'b0, cell_col} < 7'(GRID_COLS));

  always_comb begin
    grid_wr.en         = in_xfer && (mode == MODE_LOAD) && load_in_range;
    grid_wr.addr       = cell_addr(ROW_W'(cell_row), COL_W'(cell_col));
    grid_wr.data.code  = CODE_BITS'(cell_code);
    grid_wr.data.solid = cell_solid;
  end

  // a probed cell joins when it matches the start cell and is still free
  assign probe_eq = (rd_data == ref_cell) && !meshed[cur_addr];

  gtrm_grid_ram u_grid (
    .clk     (clk),
    .wr      (grid_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      simple_floor <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      simple_floor <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      meshed     <= '0;
      scan_row   <= '0;
      scan_col   <= '0;
      scan_end   <= 1'b0;
      res_status <= STATUS_LOADED;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (mode == MODE_LOAD) begin
              if (load_in_range) begin
                meshed[grid_wr.addr] <= 1'b0;
                scan_row <= '0;
                scan_col <= '0;
                scan_end <= 1'b0;
              end
              res_status <= STATUS_LOADED;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            res_status <= STATUS_NONE;
            state      <= S_DONE;
          end else if (meshed[scan_addr]) begin
            if (scan_col == COL_LAST) begin
              scan_col <= '0;
              if (scan_row == ROW_LAST) begin
                scan_end <= 1'b1;
              end else begin
                scan_row <= scan_row + 1'b1;
              end
            end else begin
              scan_col <= scan_col + 1'b1;
            end
          end else begin
            state <= S_REF;
          end
        end
        S_REF: begin
          ref_cell <= rd_data;
          w        <= W_W'(1);
          h        <= H_W'(1);
          ccount   <= W_W'(1);
          rcount   <= H_W'(1);
          if (scan_col != COL_LAST) begin
            cur_row <= scan_row;
            cur_col <= scan_col + 1'b1;
            state   <= S_WRD;
          end else if (scan_row != ROW_LAST) begin
            cur_row <= scan_row + 1'b1;
            cur_col <= scan_col;
            state   <= S_HRD;
          end else begin
            cur_row <= scan_row;
            cur_col <= scan_col;
            state   <= S_MARK;
          end
        end
        S_WRD: begin
          state <= S_WCMP;
        end
        S_WCMP: begin
          if (probe_eq) begin
            w <= w + 1'b1;
          end
          if (probe_eq && (cur_col != COL_LAST)) begin
            cur_col <= cur_col + 1'b1;
            state   <= S_WRD;
          end else if (scan_row != ROW_LAST) begin
            cur_row <= scan_row + 1'b1;
            cur_col <= scan_col;
            ccount  <= W_W'(1);
            state   <= S_HRD;
          end else begin
            cur_row <= scan_row;
            cur_col <= scan_col;
            ccount  <= W_W'(1);
            state   <= S_MARK;
          end
        end
        S_HRD: begin
          state <= S_HCMP;
        end
        S_HCMP: begin
          if (!probe_eq) begin
            cur_row <= scan_row;
            cur_col <= scan_col;
            ccount  <= W_W'(1);
            state   <= S_MARK;
          end else if (ccount != w) begin
            cur_col <= cur_col + 1'b1;
            ccount  <= ccount + 1'b1;
            state   <= S_HRD;
          end else begin
            // full run in this row, the rectangle grows down by one
            h      <= h + 1'b1;
            ccount <= W_W'(1);
            if (cur_row != ROW_LAST) begin
              cur_row <= cur_row + 1'b1;
              cur_col <= scan_col;
              state   <= S_HRD;
            end else begin
              cur_row <= scan_row;
              cur_col <= scan_col;
              state   <= S_MARK;
            end
          end
        end
        S_MARK: begin
          meshed[cur_addr] <= 1'b1;
          if (ccount != w) begin
            cur_col <= cur_col + 1'b1;
            ccount  <= ccount + 1'b1;
          end else if (rcount != h) begin
            cur_row <= cur_row + 1'b1;
            cur_col <= scan_col;
            ccount  <= W_W'(1);
            rcount  <= rcount + 1'b1;
          end else begin
            res_status <= STATUS_RECT;
            res_row    <= scan_row;
            res_col    <= scan_col;
            // scan resumes one past the start cell
            if (scan_col == COL_LAST) begin
              scan_col <= '0;
              if (scan_row == ROW_LAST) begin
                scan_end <= 1'b1;
              end else begin
                scan_row <= scan_row + 1'b1;
              end
            end else begin
              scan_col <= scan_col + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      status <= res_status;
      if (res_status == STATUS_RECT) begin
        rect_row      <= 4'(res_row);
        rect_col      <= 4'(res_col);
        rect_width    <= 5'(w);
        rect_height   <= 5'(h);
        rect_code     <= 6'(ref_cell.code);
        rect_solid    <= ref_cell.solid;
        needs_texture <= !(simple_floor && !ref_cell.solid);
      end else begin
        rect_row      <= '0;
        rect_col      <= '0;
        rect_width    <= '0;
        rect_height   <= '0;
        rect_code     <= '0;
        rect_solid    <= 1'b0;
        needs_texture <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != S_IDLE))
    else $error("block idle right after accepting an item");

  a_rect_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_RECT)) |-> ((rect_width != 5'd0) && (rect_height != 5'd0)))
    else $error("returned rectangle has zero size");

  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_RECT)) |-> ((rect_width == 5'd0) && (rect_height == 5'd0)))
    else $error("non-rectangle result carries a size");

  a_mark_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> ((ccount <= w) && (rcount <= h)))
    else $error("marking runs past the rectangle");
`endif

endmodule

>>> tb/sv/greedy_tile_rect_mesher_top_test.sv
`timescale 1ns / 100ps

module greedy_tile_rect_mesher_top_test;
  import gtrm_pkg::*;

  localparam logic MODE_FETCH = 1'b1;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] row;
    logic [3:0] col;
    logic [4:0] width;
    logic [4:0] height;
    logic [5:0] code;
    logic       solid;
    logic       needs_tex;
  } mesh_result_t;

  // shadow copy of the grid; works out each expected result when an item is accepted
  class mesh_shadow;
    logic [5:0]   tile_code [CELLS];
    logic         tile_solid [CELLS];
    bit           tile_meshed [CELLS];
    int           scan_pos;
    bit           simple_floor;
    mesh_result_t results_due[$];
    int           errors;
    int           loads_done;
    int           rects_done;
    int           empties_done;
    int           widest_area;

    function new();
      int i;
      for (i = 0; i < CELLS; i++) tile_meshed[i] = 1'b0;
      scan_pos = 0;
      simple_floor = 1'b0;
      errors = 0;
      loads_done = 0;
      rects_done = 0;
      empties_done = 0;
      widest_area = 0;
    endfunction

    function bit same_tile(int a, int b);
      return tile_code[a] == tile_code[b] && tile_solid[a] == tile_solid[b] &&
             tile_meshed[a] == tile_meshed[b];
    endfunction

    function int open_cells();
      int i, n;
      n = 0;
      for (i = 0; i < CELLS; i++) if (!tile_meshed[i]) n++;
      return n;
    endfunction

    function void take_item(logic m, logic [3:0] r, logic [3:0] c, logic [5:0] code,
                            logic s);
      mesh_result_t want;
      int idx, start, top, left, w, h, rr, cc;
      bit full;
      want = '0;
      if (m == MODE_LOAD) begin
        want.status = STATUS_LOADED;
        if (int'(r) < GRID_ROWS && int'(c) < GRID_COLS) begin
          idx = int'(r) * GRID_COLS + int'(c);
          tile_code[idx] = code;
          tile_solid[idx] = s;
          tile_meshed[idx] = 1'b0;
          scan_pos = 0;
        end
      end else begin
        while (scan_pos < CELLS && tile_meshed[scan_pos]) scan_pos++;
        if (scan_pos >= CELLS) begin
          scan_pos = CELLS;
          want.status = STATUS_NONE;
        end else begin
          start = scan_pos;
          top = start / GRID_COLS;
          left = start % GRID_COLS;
          w = 1;
          while (left + w < GRID_COLS && same_tile(start, start + w)) w++;
          h = 1;
          full = 1'b1;
          // grow down only while the whole run below matches
          while (full && top + h < GRID_ROWS) begin
            for (cc = 0; cc < w; cc++)
              if (!same_tile(start, (top + h) * GRID_COLS + left + cc)) full = 1'b0;
            if (full) h++;
          end
          for (rr = 0; rr < h; rr++)
            for (cc = 0; cc < w; cc++)
              tile_meshed[(top + rr) * GRID_COLS + left + cc] = 1'b1;
          scan_pos = start + 1;
          want.status = STATUS_RECT;
          want.row = 4'(top);
          want.col = 4'(left);
          want.width = 5'(w);
          want.height = 5'(h);
          want.code = tile_code[start];
          want.solid = tile_solid[start];
          want.needs_tex = !(simple_floor && !tile_solid[start]);
        end
      end
      results_due.insert(results_due.size(), want);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(mesh_result_t got);
      mesh_result_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = results_due.pop_front();
      check_field("status", want.status, got.status);
      check_field("rect_row", want.row, got.row);
      check_field("rect_col", want.col, got.col);
      check_field("rect_width", want.width, got.width);
      check_field("rect_height", want.height, got.height);
      check_field("rect_code", want.code, got.code);
      check_field("rect_solid", want.solid, got.solid);
      check_field("needs_texture", want.needs_tex, got.needs_tex);
      case (want.status)
        STATUS_LOADED: loads_done++;
        STATUS_RECT: begin
          rects_done++;
          if (want.width * want.height > widest_area) widest_area = want.width * want.height;
        end
        default: empties_done++;
      endcase
    endfunction
  endclass

  mesh_shadow shadow = new();

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       mode = MODE_LOAD;
  logic [3:0] cell_row = '0;
  logic [3:0] cell_col = '0;
  logic [5:0] cell_code = '0;
  logic       cell_solid = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [3:0] rect_row;
  logic [3:0] rect_col;
  logic [4:0] rect_width;
  logic [4:0] rect_height;
  logic [5:0] rect_code;
  logic       rect_solid;
  logic       needs_texture;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  int send_idle_pct = 21;
  int recv_idle_pct = 86;
  int items_sent = 0;
  int floor_writes = 0;

  greedy_tile_rect_mesher_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .cell_code    (cell_code),
    .cell_solid   (cell_solid),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .rect_row     (rect_row),
    .rect_col     (rect_col),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .rect_code    (rect_code),
    .rect_solid   (rect_solid),
    .needs_texture(needs_texture),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("FAIL greedy_tile_rect_mesher_top");
    $finish;
  end

  // result side: checks each transfer, stalls at random, and holds off twice for a long stretch
  initial begin : result_sink
    mesh_result_t got;
    int hold_left;
    int taken;
    hold_left = 0;
    taken = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = {status, rect_row, rect_col, rect_width, rect_height, rect_code, rect_solid,
               needs_texture};
        shadow.check_result(got);
        taken++;
        if (taken == 400 || taken == 1000) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic m, input logic [3:0] r, input logic [3:0] c,
                           input logic [5:0] code, input logic s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    cell_row <= r;
    cell_col <= c;
    cell_code <= code;
    cell_solid <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.take_item(m, r, c, code, s);
    items_sent++;
  endtask

  // cell fields ride along with a fetch but are ignored by the block
  task automatic fetch_rect();
    send_item(MODE_FETCH, 4'($urandom_range(15)), 4'($urandom_range(15)),
              6'($urandom_range(63)), 1'($urandom_range(1)));
  endtask

  task automatic fill_block(input int top, input int left, input int h, input int w,
                            input logic [5:0] code, input logic s);
    int r, c;
    for (r = top; r < top + h && r < GRID_ROWS; r++)
      for (c = left; c < left + w && c < GRID_COLS; c++)
        send_item(MODE_LOAD, 4'(r), 4'(c), code, s);
  endtask

  task automatic mesh_all(input int extra);
    while (shadow.open_cells() > 0) fetch_rect();
    repeat (extra) fetch_rect();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (shadow.results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_floor(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow.simple_floor = v;
    floor_writes++;
  endtask

  // few distinct codes so that equal neighbors are common
  function automatic logic [5:0] pick_code();
    case ($urandom_range(3))
      0: return 6'd0;
      1: return 6'd63;
      default: return 6'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic random_episode();
    int kind, n, i, top, left, h, w;
    kind = $urandom_range(0, 49);
    if (kind == 0) begin
      // whole grid rewritten in bands
      h = $urandom_range(1, 16);
      w = $urandom_range(1, 16);
      for (top = 0; top < GRID_ROWS; top++)
        for (left = 0; left < GRID_COLS; left++)
          send_item(MODE_LOAD, 4'(top), 4'(left), 6'((top / h + 2 * (left / w)) % 3),
                    1'((left / w) % 2));
      mesh_all(1);
    end else if (kind < 25) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0) begin
          h = $urandom_range(1, 16);
          w = $urandom_range(1, 16);
        end else begin
          h = $urandom_range(1, 5);
          w = $urandom_range(1, 5);
        end
        fill_block($urandom_range(15), $urandom_range(15), h, w, pick_code(),
                   1'($urandom_range(1)));
      end
      mesh_all($urandom_range(0, 2));
    end else if (kind < 35) begin
      // scattered cells with any code, then only part of the mesh is fetched
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++)
        send_item(MODE_LOAD, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  $urandom_range(1) ? pick_code() : 6'($urandom_range(63)),
                  1'($urandom_range(1)));
      repeat ($urandom_range(1, 6)) fetch_rect();
    end else if (kind < 45) begin
      // a load in the middle of meshing restarts the scan
      n = $urandom_range(1, 2);
      for (i = 0; i < n; i++)
        fill_block($urandom_range(15), $urandom_range(15), $urandom_range(1, 6),
                   $urandom_range(1, 6), pick_code(), 1'($urandom_range(1)));
      repeat ($urandom_range(1, 3)) fetch_rect();
      send_item(MODE_LOAD, 4'($urandom_range(15)), 4'($urandom_range(15)), pick_code(),
                1'($urandom_range(1)));
      mesh_all(1);
    end else if (kind < 48) begin
      repeat ($urandom_range(1, 3)) fetch_rect();
    end else begin
      settle();
      write_floor(1'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    int r, c, phase, base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_floor(1'b0);

    // uniform grid gives one full-size rectangle, then the scan stays finished
    for (r = 0; r < GRID_ROWS; r++)
      for (c = 0; c < GRID_COLS; c++)
        send_item(MODE_LOAD, 4'(r), 4'(c), 6'd63, 1'b1);
    fetch_rect();
    fetch_rect();
    fetch_rect();
    // lone cells found only after skipping meshed ones
    send_item(MODE_LOAD, 4'd15, 4'd15, 6'd0, 1'b0);
    fetch_rect();
    send_item(MODE_LOAD, 4'd0, 4'd0, 6'd0, 1'b0);
    send_item(MODE_LOAD, 4'd0, 4'd15, 6'd5, 1'b0);
    fetch_rect();
    fetch_rect();
    fetch_rect();
    settle();
    write_floor(1'b1);
    // same code, different solid flag: two rectangles, floor one without texture
    send_item(MODE_LOAD, 4'd15, 4'd14, 6'd0, 1'b1);
    send_item(MODE_LOAD, 4'd15, 4'd15, 6'd0, 1'b0);
    fetch_rect();
    fetch_rect();
    // downward growth stops at a shorter row
    fill_block(5, 2, 2, 3, 6'd9, 1'b0);
    fill_block(7, 2, 1, 2, 6'd9, 1'b0);
    fetch_rect();
    fetch_rect();
    fetch_rect();

    base = items_sent;
    for (phase = 0; phase < 3; phase++) begin
      if (phase > 0) begin
        settle();
        send_idle_pct = (phase == 1) ? 86 : 0;
        recv_idle_pct = (phase == 1) ? 21 : 0;
        write_floor(phase == 1 ? 1'b0 : 1'b1);
      end
      while (items_sent < base + (phase + 1) * ITEMS_PER_PHASE) random_episode();
    end

    settle();
    repeat (20) @(posedge clk);
    $display("run covered %0d items: %0d loads, %0d rectangles (largest %0d cells), %0d empty",
             items_sent, shadow.loads_done, shadow.rects_done, shadow.widest_area,
             shadow.empties_done);
    $display("simple_floor written %0d times across three stall mixes, %0d check errors",
             floor_writes, shadow.errors);
    if (shadow.errors == 0 && shadow.results_due.size() == 0) begin
      $display("PASS greedy_tile_rect_mesher_top");
    end else begin
      $display("FAIL greedy_tile_rect_mesher_top");
    end
    $finish;
  end

endmodule
